// ===== sv/pal_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_pkg: shared types and codes for the positional array list
// Word formats, operation codes and the control group sent down the cell row.
// ----------------------------------------------------------------------------
package pal_pkg;

  localparam logic [2:0] OP_INS_END   = 3'd0;
  localparam logic [2:0] OP_INS_FRONT = 3'd1;
  localparam logic [2:0] OP_INS_AT    = 3'd2;
  localparam logic [2:0] OP_REM_END   = 3'd3;
  localparam logic [2:0] OP_REM_FRONT = 3'd4;
  localparam logic [2:0] OP_REM_AT    = 3'd5;
  localparam logic [2:0] OP_SEARCH    = 3'd6;
  localparam logic [2:0] OP_CLEAR     = 3'd7;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] value;
    logic [6:0]         position;
  } in_word_t;

  typedef struct packed {
    logic       accepted;
    logic [6:0] found_position;
    logic [6:0] entry_count;
    logic       is_full;
    logic       is_empty;
  } out_word_t;

  typedef enum logic [1:0] {
    CM_HOLD = 2'd0,
    CM_INS  = 2'd1,
    CM_REM  = 2'd2
  } cell_mode_e;

  typedef struct packed {
    cell_mode_e  mode;
    logic [31:0] data;
  } cell_ctl_t;

endpackage

// ===== sv/pal_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_cell: one slot of the list
// Holds one entry, shifts toward or away from its neighbors and keeps a
// registered match flag against the broadcast key.
// ----------------------------------------------------------------------------
module pal_cell import pal_pkg::*; #(
  parameter int IW  = 6,
  parameter int CW  = 7,
  parameter int IDX = 0
) (
  input  logic          clk_i,
  input  cell_ctl_t     ctl_i,
  input  logic [IW-1:0] slot_i,
  input  logic [CW-1:0] count_i,
  input  logic [31:0]   left_i,
  input  logic [31:0]   right_i,
  output logic [31:0]   entry_o,
  output logic          match_o
);

  logic [31:0] entry_q, entry_d;
  logic        match_q;
  logic        above, at;

  assign above = IW'(IDX) > slot_i;
  assign at    = IW'(IDX) == slot_i;

  always_comb begin
    entry_d = entry_q;
    unique case (ctl_i.mode)
      CM_INS: begin
        if (above) entry_d = left_i;
        else if (at) entry_d = ctl_i.data;
      end
      CM_REM: begin
        if (above || at) entry_d = right_i;
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    // only slots inside the live part of the list may report a hit
    match_q <= (entry_q == ctl_i.data) && (CW'(IDX) < count_i);
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

// ===== sv/positional_array_list_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_array_list_top: bounded ordered list on a row of shift cells
// Inserts, and removes other than at the end, shift the cell row; search
// compares in every cell and scans the hit flags eight slots per cycle.
// ----------------------------------------------------------------------------
// result: inserts, removes and clear put their result word in the output
//   register at the accepting edge; a search registers the hit flags, then
//   scans them eight slots at a time until the first hit or the last group
// throughput: one non-search word per cycle while the output is drained
// reset: count and handshake state clear at once; cell contents stay as they are
module positional_array_list_top import pal_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int IW    = $clog2(CAPACITY);
  localparam int CMPW  = (CW > 7) ? CW + 1 : 8;
  localparam int NGRP  = (CAPACITY + 7) / 8;
  localparam int GW    = (NGRP > 1) ? $clog2(NGRP) : 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_SCAN = 3'b100
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic          out_valid_q, out_valid_d;
  out_word_t     out_q, out_d;
  logic [31:0]   key_q, key_d;
  logic [GW-1:0] ptr_q, ptr_d;

  cell_ctl_t     ctl;
  logic [IW-1:0] slot;
  logic          acc, full, empty, ok;
  logic [CMPW-1:0] pos_w, cnt_w;

  logic [31:0] entries_w [CAPACITY];
  logic        match_w [CAPACITY];
  logic [7:0]  grp_arr [NGRP];
  logic [7:0]  grp;
  logic [2:0]  hit_idx;
  logic        hit;
  logic [GW+3:0] found_w;

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign acc        = in_valid_i && in_ready_o;
  assign full       = count_q == CW'(CAPACITY);
  assign empty      = count_q == '0;
  assign pos_w      = CMPW'(in_word_i.position);
  assign cnt_w      = CMPW'(count_q);

  // cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [31:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = entries_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = entries_w[i];
    end else begin : g_mid_r
      assign right_w = entries_w[i+1];
    end
    pal_cell #(
      .IW  (IW),
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .slot_i  (slot),
      .count_i (count_q),
      .left_i  (left_w),
      .right_i (right_w),
      .entry_o (entries_w[i]),
      .match_o (match_w[i])
    );
  end

  // hit flags grouped by eight, padded past the last cell
  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    for (genvar b = 0; b < 8; b++) begin : g_bit
      if (g * 8 + b < CAPACITY) begin : g_real
        assign grp_arr[g][b] = match_w[g*8+b];
      end else begin : g_pad
        assign grp_arr[g][b] = 1'b0;
      end
    end
  end

  assign grp = grp_arr[ptr_q];

  always_comb begin
    hit     = 1'b0;
    hit_idx = 3'd0;
    for (int b = 7; b >= 0; b--) begin
      if (grp[b]) begin
        hit     = 1'b1;
        hit_idx = 3'(b);
      end
    end
  end

  assign found_w = {1'b0, ptr_q, hit_idx} + (GW + 4)'(1);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    key_d       = key_q;
    ptr_d       = ptr_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ctl.mode    = CM_HOLD;
    ctl.data    = (state_q == ST_IDLE) ? in_word_i.value : key_q;
    slot        = '0;
    ok          = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          unique case (in_word_i.operation)
            OP_INS_END: begin
              if (!full) begin
                ctl.mode = CM_INS;
                slot     = IW'(count_q);
                count_d  = count_q + CW'(1);
                ok       = 1'b1;
              end
            end
            OP_INS_FRONT: begin
              if (!full) begin
                ctl.mode = CM_INS;
                count_d  = count_q + CW'(1);
                ok       = 1'b1;
              end
            end
            OP_INS_AT: begin
              if (!full && pos_w != '0 && pos_w <= cnt_w + CMPW'(1)) begin
                ctl.mode = CM_INS;
                slot     = IW'(pos_w - CMPW'(1));
                count_d  = count_q + CW'(1);
                ok       = 1'b1;
              end
            end
            OP_REM_END: begin
              if (!empty) begin
                count_d = count_q - CW'(1);
                ok      = 1'b1;
              end
            end
            OP_REM_FRONT: begin
              if (!empty) begin
                ctl.mode = CM_REM;
                count_d  = count_q - CW'(1);
                ok       = 1'b1;
              end
            end
            OP_REM_AT: begin
              if (!empty && pos_w != '0 && pos_w <= cnt_w) begin
                ctl.mode = CM_REM;
                slot     = IW'(pos_w - CMPW'(1));
                count_d  = count_q - CW'(1);
                ok       = 1'b1;
              end
            end
            OP_SEARCH: begin
              key_d   = in_word_i.value;
              ptr_d   = '0;
              state_d = ST_CMP;
            end
            default: begin
              count_d = '0;
              ok      = 1'b1;
            end
          endcase
          if (in_word_i.operation != OP_SEARCH) begin
            out_d.accepted       = ok;
            out_d.found_position = '0;
            out_d.entry_count    = 7'(count_d);
            out_d.is_full        = count_d == CW'(CAPACITY);
            out_d.is_empty       = count_d == '0;
            out_valid_d          = 1'b1;
          end
        end
      end
      ST_CMP: begin
        // hit flags register during this cycle
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (hit || ptr_q == GW'(NGRP - 1)) begin
          out_d.accepted       = 1'b1;
          out_d.found_position = hit ? 7'(found_w) : 7'd0;
          out_d.entry_count    = 7'(count_q);
          out_d.is_full        = full;
          out_d.is_empty       = empty;
          out_valid_d          = 1'b1;
          state_d              = ST_IDLE;
        end else begin
          ptr_d = ptr_q + GW'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    key_q <= key_d;
    ptr_q <= ptr_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule
